// File: design/cwlf_pkg.sv
// ----------------------------------------------------------------------------
// cwlf_pkg
// Shared types and constants for the cross window label fill block.
// ----------------------------------------------------------------------------
package cwlf_pkg;

  localparam int unsigned ROW_W = 16;  // row pointer width
  localparam int unsigned KW    = 17;  // arm scan counter and bound width
  localparam int unsigned NW    = 7;   // effective window size width
  localparam int unsigned HW    = 6;   // half arm width

  typedef enum logic [1:0] {
    CFG_WIDTH  = 2'd0,
    CFG_HEIGHT = 2'd1,
    CFG_WINDOW = 2'd2
  } cfg_idx_e;

  typedef enum logic {
    CMD_PIXEL = 1'b0,
    CMD_DRAIN = 1'b1
  } cmd_e;

  typedef struct packed {
    logic               cmd;
    logic        [31:0] elevation;
    logic signed [7:0]  clean_label;
    logic signed [7:0]  neighbor_count;
  } in_beat_t;

  typedef struct packed {
    logic signed [7:0] label;
    logic [15:0]       out_row;
    logic [9:0]        out_col;
    logic              last_pixel;
  } out_beat_t;

  // controller to datapath
  typedef struct packed {
    logic accept;     // take input beat: store pixel, advance write pointers
    logic ctr_load;   // capture centre entry from read data
    logic init_h;     // set up horizontal arm scan
    logic init_v;     // set up vertical arm scan
    logic rd_h;       // read address from horizontal arm
    logic rd_v;       // read address from vertical arm
    logic arm_step;   // evaluate read data and advance scan
    logic emit;       // load output register, advance emit pointers
  } cwlf_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic ready;      // next pending pixel may be emitted
    logic ctr_zero;   // captured centre has clean label zero
    logic arm_last;   // current scan position is the last of the arm
    logic out_free;   // output register can take a beat
  } cwlf_sts_t;

  // exact float equality, +0 equals -0, NaN never matches
  function automatic logic elev_eq(input logic [31:0] a, input logic [31:0] b);
    logic nan_a;
    logic nan_b;
    nan_a = a[30:0] > 31'h7F800000;
    nan_b = b[30:0] > 31'h7F800000;
    if (nan_a || nan_b) begin
      return 1'b0;
    end
    if ((a[30:0] | b[30:0]) == 31'd0) begin
      return 1'b1;
    end
    return a == b;
  endfunction

endpackage

// File: design/cwlf_ctrl.sv
// ----------------------------------------------------------------------------
// cwlf_ctrl
// Sequencer: accept a beat, check readiness (back to idle if not ready), read the
// centre, scan both arms one entry at a time unless the centre already carries a label, then emit.
// ----------------------------------------------------------------------------
module cwlf_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  cwlf_pkg::cwlf_sts_t sts_i,
  output cwlf_pkg::cwlf_cmd_t cmd_o
);
  import cwlf_pkg::*;

  typedef enum logic [7:0] {
    ST_IDLE  = 8'b0000_0001,
    ST_CHECK = 8'b0000_0010,
    ST_CTR   = 8'b0000_0100,
    ST_HA    = 8'b0000_1000,
    ST_HE    = 8'b0001_0000,
    ST_VA    = 8'b0010_0000,
    ST_VE    = 8'b0100_0000,
    ST_EMIT  = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = ST_CHECK;
        end
      end
      ST_CHECK: begin
        // centre address is presented here
        state_d = sts_i.ready ? ST_CTR : ST_IDLE;
      end
      ST_CTR: begin
        cmd_o.ctr_load = 1'b1;
        cmd_o.init_h   = 1'b1;
        state_d        = ST_HA;
      end
      ST_HA: begin
        // drop the scan when the centre already carries a label
        if (sts_i.ctr_zero) begin
          cmd_o.rd_h = 1'b1;
          state_d    = ST_HE;
        end else begin
          state_d = ST_EMIT;
        end
      end
      ST_HE: begin
        cmd_o.arm_step = 1'b1;
        if (sts_i.arm_last) begin
          cmd_o.init_v = 1'b1;
          state_d      = ST_VA;
        end else begin
          state_d = ST_HA;
        end
      end
      ST_VA: begin
        cmd_o.rd_v = 1'b1;
        state_d    = ST_VE;
      end
      ST_VE: begin
        cmd_o.arm_step = 1'b1;
        state_d        = sts_i.arm_last ? ST_EMIT : ST_VA;
      end
      ST_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = (state_q != ST_IDLE);

endmodule

// File: design/cwlf_dp.sv
// ----------------------------------------------------------------------------
// cwlf_dp
// Datapath: configuration, row store ring, raster pointers, arm scan and
// output register.
// ----------------------------------------------------------------------------
module cwlf_dp #(
  parameter int unsigned MAX_WIDTH  = 1024,
  parameter int unsigned MAX_WINDOW = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [1:0]          cfg_idx_i,
  input  logic [15:0]         cfg_data_i,
  input  cwlf_pkg::in_beat_t  in_data_i,
  input  cwlf_pkg::cwlf_cmd_t cmd_i,
  output cwlf_pkg::cwlf_sts_t sts_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output cwlf_pkg::out_beat_t out_data_o
);
  import cwlf_pkg::*;

  localparam int unsigned CW    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int unsigned RS    = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int unsigned DEPTH = MAX_WIDTH * MAX_WINDOW;
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  // configuration
  logic [10:0] cfg_w_q;
  logic [15:0] cfg_h_q;
  logic [4:0]  cfg_n_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_w_q <= 11'd1024;
      cfg_h_q <= 16'd65535;
      cfg_n_q <= 5'd5;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_WIDTH:  cfg_w_q <= cfg_data_i[10:0];
        CFG_HEIGHT: cfg_h_q <= cfg_data_i;
        CFG_WINDOW: cfg_n_q <= cfg_data_i[4:0];
        default: ;
      endcase
    end
  end

  logic [KW-1:0] w_eff, h_eff;
  logic [NW-1:0] n_eff;
  logic [HW-1:0] wl, wr;

  always_comb begin
    if (cfg_w_q == 11'd0) begin
      w_eff = KW'(1);
    end else if (KW'(cfg_w_q) > KW'(MAX_WIDTH)) begin
      w_eff = KW'(MAX_WIDTH);
    end else begin
      w_eff = KW'(cfg_w_q);
    end
    h_eff = (cfg_h_q == 16'd0) ? KW'(1) : KW'(cfg_h_q);
    if (cfg_n_q == 5'd0) begin
      n_eff = NW'(1);
    end else if (NW'(cfg_n_q) > NW'(MAX_WINDOW)) begin
      n_eff = NW'(MAX_WINDOW);
    end else begin
      n_eff = NW'(cfg_n_q);
    end
    wl = HW'((n_eff - NW'(1)) >> 1);
    wr = HW'(n_eff - NW'(1) - NW'(wl));
  end

  // raster pointers
  logic [ROW_W-1:0] in_row_q, emit_row_q;
  logic [CW-1:0]    in_col_q, emit_col_q;
  logic [RS-1:0]    in_slot_q, emit_slot_q;

  logic wrap_now;
  assign wrap_now = (KW'(in_row_q) >= h_eff) && (KW'(emit_row_q) >= h_eff);

  logic [ROW_W-1:0] in_row_n;
  logic [CW-1:0]    in_col_n;
  logic [RS-1:0]    in_slot_n;
  assign in_row_n  = wrap_now ? '0 : in_row_q;
  assign in_col_n  = wrap_now ? '0 : in_col_q;
  assign in_slot_n = wrap_now ? '0 : in_slot_q;

  logic do_write;
  assign do_write = cmd_i.accept && (in_data_i.cmd == CMD_PIXEL)
                    && (KW'(in_row_n) < h_eff);

  // a pixel landing on a finished image is dropped and emits nothing
  logic drop_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      drop_q <= 1'b0;
    end else if (cmd_i.accept) begin
      drop_q <= (in_data_i.cmd == CMD_PIXEL) && (KW'(in_row_n) >= h_eff);
    end
  end

  function automatic logic [RS-1:0] slot_inc(input logic [RS-1:0] s);
    return (s == RS'(MAX_WINDOW - 1)) ? '0 : s + RS'(1);
  endfunction

  function automatic logic [AW-1:0] addr_of(input logic [RS-1:0] s, input logic [CW-1:0] c);
    return AW'(AW'(s) * AW'(MAX_WIDTH)) + AW'(c);
  endfunction

  logic in_col_end, emit_col_end;
  assign in_col_end   = (KW'(in_col_n) + KW'(1)) >= w_eff;
  assign emit_col_end = (KW'(emit_col_q) + KW'(1)) >= w_eff;

  // last pixel of a fully received image: return all pointers to the origin
  logic emit_wrap;
  assign emit_wrap = emit_col_end && ((KW'(emit_row_q) + KW'(1)) >= h_eff)
                     && (KW'(in_row_q) >= h_eff);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_row_q    <= '0;
      in_col_q    <= '0;
      in_slot_q   <= '0;
      emit_row_q  <= '0;
      emit_col_q  <= '0;
      emit_slot_q <= '0;
    end else if (cmd_i.accept) begin
      if (wrap_now) begin
        emit_row_q  <= '0;
        emit_col_q  <= '0;
        emit_slot_q <= '0;
      end
      if (do_write) begin
        if (in_col_end) begin
          in_col_q  <= '0;
          in_row_q  <= in_row_n + ROW_W'(1);
          in_slot_q <= slot_inc(in_slot_n);
        end else begin
          in_col_q  <= in_col_n + CW'(1);
          in_row_q  <= in_row_n;
          in_slot_q <= in_slot_n;
        end
      end else begin
        in_row_q  <= in_row_n;
        in_col_q  <= in_col_n;
        in_slot_q <= in_slot_n;
      end
    end else if (cmd_i.emit) begin
      if (emit_wrap) begin
        in_row_q    <= '0;
        in_col_q    <= '0;
        in_slot_q   <= '0;
        emit_row_q  <= '0;
        emit_col_q  <= '0;
        emit_slot_q <= '0;
      end else if (emit_col_end) begin
        emit_col_q  <= '0;
        emit_row_q  <= emit_row_q + ROW_W'(1);
        emit_slot_q <= slot_inc(emit_slot_q);
      end else begin
        emit_col_q <= emit_col_q + CW'(1);
      end
    end
  end

  // readiness of the next pending pixel
  logic [KW-1:0] lim;
  assign lim = KW'(emit_row_q) + KW'(wr);
  assign sts_o.ready = !drop_q && (KW'(emit_row_q) < h_eff)
                       && ((KW'(in_row_q) >= h_eff) || (KW'(in_row_q) > lim)
                           || ((KW'(in_row_q) == lim) && (in_col_q > emit_col_q)));

  // arm scan
  logic [KW-1:0] k_q, hi_q;
  logic [RS-1:0] kslot_q;
  logic          vert_q;
  logic          hit_q;
  logic [31:0]   ctr_elev_q;
  logic signed [7:0] ctr_clean_q, ctr_cnt_q;

  logic [KW-1:0] ec_k, er_k;
  logic [KW-1:0] lo_h, hi_h, lo_v, hi_v, hi_h_raw, hi_v_raw;
  logic [HW-1:0] dv;
  logic [RS:0]   lo_slot_w;
  logic [RS-1:0] lo_slot;

  always_comb begin
    ec_k     = KW'(emit_col_q);
    er_k     = KW'(emit_row_q);
    lo_h     = (ec_k > KW'(wl)) ? ec_k - KW'(wl) : '0;
    hi_h_raw = ec_k + KW'(wr) + KW'(1);
    hi_h     = (hi_h_raw < w_eff) ? hi_h_raw : w_eff;
    lo_v     = (er_k > KW'(wl)) ? er_k - KW'(wl) : '0;
    hi_v_raw = er_k + KW'(wr) + KW'(1);
    hi_v     = (hi_v_raw < h_eff) ? hi_v_raw : h_eff;
    dv       = HW'(er_k - lo_v);
    // step back dv rows around the ring
    if ((RS + 1)'(emit_slot_q) >= (RS + 1)'(dv)) begin
      lo_slot_w = (RS + 1)'(emit_slot_q) - (RS + 1)'(dv);
    end else begin
      lo_slot_w = (RS + 1)'(emit_slot_q) + (RS + 1)'(MAX_WINDOW) - (RS + 1)'(dv);
    end
    lo_slot = lo_slot_w[RS-1:0];
  end

  // row store
  logic [47:0]   mem [DEPTH];
  logic [47:0]   rdata_q;
  logic [AW-1:0] rd_addr;

  always_comb begin
    if (cmd_i.rd_h) begin
      rd_addr = addr_of(emit_slot_q, k_q[CW-1:0]);
    end else if (cmd_i.rd_v) begin
      rd_addr = addr_of(kslot_q, emit_col_q);
    end else begin
      rd_addr = addr_of(emit_slot_q, emit_col_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_write) begin
      mem[addr_of(in_slot_n, in_col_n)] <= {in_data_i.elevation, in_data_i.clean_label,
                                            in_data_i.neighbor_count};
    end
    rdata_q <= mem[rd_addr];
  end

  logic signed [7:0] rd_clean;
  logic              rd_hit, k_centre;
  assign rd_clean = rdata_q[15:8];
  assign k_centre = vert_q ? (k_q == er_k) : (k_q == ec_k);
  assign rd_hit   = !k_centre && (rd_clean > 8'sd0) && elev_eq(ctr_elev_q, rdata_q[47:16]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q       <= 1'b0;
      ctr_clean_q <= '0;
      vert_q      <= 1'b0;
    end else begin
      if (cmd_i.ctr_load) begin
        ctr_elev_q  <= rdata_q[47:16];
        ctr_clean_q <= rdata_q[15:8];
        ctr_cnt_q   <= rdata_q[7:0];
        hit_q       <= 1'b0;
      end else if (cmd_i.arm_step && rd_hit) begin
        hit_q <= 1'b1;
      end
      if (cmd_i.init_h) begin
        k_q    <= lo_h;
        hi_q   <= hi_h;
        vert_q <= 1'b0;
      end else if (cmd_i.init_v) begin
        k_q     <= lo_v;
        hi_q    <= hi_v;
        kslot_q <= lo_slot;
        vert_q  <= 1'b1;
      end else if (cmd_i.arm_step) begin
        k_q     <= k_q + KW'(1);
        kslot_q <= slot_inc(kslot_q);
      end
    end
  end

  assign sts_o.ctr_zero = (ctr_clean_q == 8'sd0);
  assign sts_o.arm_last = (k_q + KW'(1)) >= hi_q;

  // output register
  logic      out_valid_q;
  out_beat_t out_q;
  logic signed [7:0] base_lab;

  always_comb begin
    if (ctr_cnt_q > 8'sd0) begin
      base_lab = ctr_clean_q;
    end else if (ctr_cnt_q == -8'sd1) begin
      base_lab = -8'sd1;
    end else begin
      base_lab = 8'sd0;
    end
    if ((ctr_clean_q == 8'sd0) && hit_q) begin
      base_lab = ctr_cnt_q;
    end
  end

  assign sts_o.out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_q.label      <= base_lab;
      out_q.out_row    <= emit_row_q;
      out_q.out_col    <= 10'(emit_col_q);
      out_q.last_pixel <= ((er_k + KW'(1)) >= h_eff) && emit_col_end;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // a label is only filled in when the centre had none
  a_hit_needs_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hit_q |-> (ctr_clean_q == 8'sd0))
    else $error("arm hit recorded for labelled centre");

  // arm scan never runs past its bound
  a_scan_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.arm_step |-> (k_q < hi_q))
    else $error("arm scan beyond bound");

  // a result is never produced over a beat still waiting
  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |-> (!out_valid_q || !out_stall_i))
    else $error("emit over held output beat");

  // emitted row always lies inside the image
  a_emit_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |-> (KW'(emit_row_q) < h_eff))
    else $error("emit beyond last row");

endmodule

// File: design/cross_window_label_fill.sv
// Sequence: an item that is not ready returns to idle after the check; when the
// centre is already labelled it goes straight to emit; otherwise both arms are
// scanned (arm length up to window_size each), then emit waits on out_stall_i.
// Throughput: one item at a time; each arm entry needs a read and an evaluate
// state on the single read port of the row store.
// Reset: pointers and configuration return to defaults; row store not cleared.
// ----------------------------------------------------------------------------
// cross_window_label_fill
// Second-pass label fill over a raster using a cross window on the rows kept.
// ----------------------------------------------------------------------------
module cross_window_label_fill #(
  parameter int unsigned MAX_WIDTH  = 1024,
  parameter int unsigned MAX_WINDOW = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [1:0]          cfg_idx_i,
  input  logic [15:0]         cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  cwlf_pkg::in_beat_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output cwlf_pkg::out_beat_t out_data_o
);
  import cwlf_pkg::*;

  cwlf_cmd_t cmd;
  cwlf_sts_t sts;

  cwlf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  cwlf_dp #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_WINDOW (MAX_WINDOW)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule
